// ----- rtl/rmn_pkg.sv -----
// Package with widths, payload types and control structs of the regret-matching normalizer.
package rmn_pkg;

  localparam int MAX_ACTIONS = 64;
  localparam int VAL_W       = 31;
  localparam int FRAC_W      = 16;
  localparam int Q_W         = FRAC_W + 1;
  localparam int NUM_W       = VAL_W + FRAC_W;
  localparam int IDX_W       = $clog2(MAX_ACTIONS);
  localparam int CNT_W       = $clog2(MAX_ACTIONS + 1);
  localparam int SUM_W       = VAL_W + $clog2(MAX_ACTIONS);
  localparam int ADDR_W      = IDX_W + 1;
  localparam int STEP_W      = $clog2(Q_W);

  localparam logic [Q_W-1:0] ONE_Q16 = Q_W'(1) << FRAC_W;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } in_t;

  typedef struct packed {
    logic [5:0]  action_index;
    logic [16:0] probability;
    logic        final_res;
  } out_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
  } desc_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic wr_bank;
    logic rd_bank;
  } fifo_stat_t;

endpackage

// ----- rtl/regret_matching_normalizer.sv -----
// Top level of the regret-matching normalizer.
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_ready    in_data   (value, last)
//   out_     output     out_valid / out_ready  out_data  (action_index, probability, final_res)
//
// A set of n actions yields n results for n up to MAX_ACTIONS; later values of a longer set are dropped.
// Each result is made in steps: the store is read (together with loading the previous result into
// the output register), the divider is started, runs its 17 divider steps and is seen to finish.
// Two banks of the value store let the next set load while the previous one is divided;
// the input stalls only while two closed sets wait.
// Reset is synchronous and active low; the store needs no clearing after reset.
module regret_matching_normalizer import rmn_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  fifo_stat_t        fifo_stat;
  desc_t             push_desc;
  desc_t             head;
  logic              push;
  logic              pop;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [VAL_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [VAL_W-1:0]  ram_rdata;

  rmn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .fifo_stat (fifo_stat),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .push      (push),
    .push_desc (push_desc)
  );

  rmn_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .stat      (fifo_stat)
  );

  rmn_ram #(
    .WIDTH (VAL_W),
    .DEPTH (2 * MAX_ACTIONS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rmn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .fifo_stat (fifo_stat),
    .head      (head),
    .pop       (pop),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/rmn_ram.sv -----
// Simple dual-port RAM with one write port and one registered read port.
module rmn_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/rmn_front.sv -----
// Front end: accepts input transactions, clamps and stores values, and closes each set.
module rmn_front import rmn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_data,
  input  fifo_stat_t        fifo_stat,
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output logic [VAL_W-1:0]  ram_wdata,
  output logic              push,
  output desc_t             push_desc
);

  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;
  logic             add_en;
  logic [VAL_W-1:0] pos;
  logic [SUM_W-1:0] sum_add;
  logic [CNT_W-1:0] cnt_add;

  assign in_ready  = !fifo_stat.full;
  assign accept    = in_valid && in_ready;
  assign pos       = in_data.value[31] ? '0 : in_data.value[VAL_W-1:0];
  assign add_en    = cnt_r < CNT_W'(MAX_ACTIONS);
  assign sum_add   = add_en ? sum_r + SUM_W'(pos) : sum_r;
  assign cnt_add   = add_en ? cnt_r + CNT_W'(1) : cnt_r;

  assign ram_we    = accept && add_en;
  assign ram_waddr = {fifo_stat.wr_bank, cnt_r[IDX_W-1:0]};
  assign ram_wdata = pos;

  assign push          = accept && in_data.last;
  assign push_desc.sum = sum_add;
  assign push_desc.cnt = cnt_add;

  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      if (in_data.last) begin
        sum_nxt = '0;
        cnt_nxt = '0;
      end else begin
        sum_nxt = sum_add;
        cnt_nxt = cnt_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/rmn_fifo.sv -----
// Two-entry queue of closed sets; each entry owns one bank of the value store.
module rmn_fifo import rmn_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  desc_t      push_desc,
  input  logic       pop,
  output desc_t      head,
  output fifo_stat_t stat
);

  desc_t      entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] level_r, level_nxt;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    level_nxt  = level_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  assign head         = entry_r[rd_ptr_r];
  assign stat.empty   = level_r == 2'd0;
  assign stat.full    = level_r == 2'd2;
  assign stat.wr_bank = wr_ptr_r;
  assign stat.rd_bank = rd_ptr_r;

endmodule

// ----- rtl/rmn_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
module rmn_div import rmn_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [SUM_W-1:0] den,
  output logic             done,
  output logic [Q_W-1:0]   quot
);

  logic [SUM_W-1:0]  den_r;
  logic [SUM_W-1:0]  rem_r, rem_nxt;
  logic [Q_W-1:0]    sh_r, sh_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [SUM_W:0]    trial;
  logic              fits;

  assign trial = {rem_r, sh_r[Q_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = SUM_W'(num[NUM_W-1:Q_W]);
      sh_nxt   = num[Q_W-1:0];
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = fits ? SUM_W'(trial - {1'b0, den_r}) : trial[SUM_W-1:0];
      sh_nxt   = {sh_r[Q_W-2:0], fits};
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(Q_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
    end
    rem_r  <= rem_nxt;
    sh_r   <= sh_nxt;
    step_r <= step_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quot = sh_r;

endmodule

// ----- rtl/rmn_back.sv -----
// Back end: reads each stored value of a closed set, divides it by the sum (1.0 by the count if zero) and presents it.
module rmn_back import rmn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  fifo_stat_t        fifo_stat,
  input  desc_t             head,
  output logic              pop,
  output logic              ram_re,
  output logic [ADDR_W-1:0] ram_raddr,
  input  logic [VAL_W-1:0]  ram_rdata,
  output logic              out_valid,
  input  logic              out_ready,
  output out_t              out_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_DIV  = 4'b0100,
    S_WAIT = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r;
  logic             load_out;
  logic             is_last;
  logic             zero_sum;
  logic             div_start;
  logic             div_done;
  logic [NUM_W-1:0] div_num;
  logic [SUM_W-1:0] div_den;
  logic [Q_W-1:0]   div_quot;

  assign zero_sum  = head.sum == '0;
  assign is_last   = (CNT_W'(k_r) + CNT_W'(1)) == head.cnt;
  assign div_num   = zero_sum ? NUM_W'(ONE_Q16) : {ram_rdata, FRAC_W'(0)};
  assign div_den   = zero_sum ? SUM_W'(head.cnt) : head.sum;
  assign div_start = state_r == S_RD;
  assign load_out  = (state_r == S_WAIT) && (!out_valid_r || out_ready);
  assign pop       = load_out && is_last;
  assign ram_raddr = {fifo_stat.rd_bank, k_nxt};

  rmn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    ram_re    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (!fifo_stat.empty) begin
          k_nxt     = '0;
          ram_re    = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (load_out) begin
          if (is_last) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + IDX_W'(1);
            ram_re    = 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.action_index <= 6'(k_r);
      out_data_r.probability  <= div_quot;
      out_data_r.final_res    <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/rmn_checker.sv -----
// Port-level checker of the regret-matching normalizer and its bind statement.
module rmn_checker import rmn_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_data,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // A stalled input transaction must hold.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("Input changed while stalled.");

  // A stalled result transaction must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Result changed while stalled.");

  // A probability never exceeds 1.0.
  a_prob_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.probability <= 17'd65536)
    else $error("Probability above 1.0.");

  // After reset no result is pending and the input side is open.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("Block not idle after reset.");

  // A new result after a non-final one carries the next action index.
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.final_res ##1 out_valid
      |-> out_data.action_index == $past(out_data.action_index) + 6'd1)
    else $error("Action index did not advance.");

endmodule

bind regret_matching_normalizer rmn_checker u_rmn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- tb/tb.sv -----
// Self-checking testbench for the regret-matching normalizer with a built-in predictor.
module tb;
  import rmn_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 78;
  localparam int CALM_ITEMS   = 30;

  typedef enum int {MIXED, NONNEG, NONPOS} set_flavor_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  in_t  pending_actions[$];
  out_t expected_probs[$];

  logic [VAL_W-1:0] clamped_weights [MAX_ACTIONS];
  logic [SUM_W-1:0] weight_sum   = '0;
  int               weight_count = 0;

  int   cycle_count = 0;
  int   mismatches  = 0;
  bit   in_taken    = 1'b0;
  bit   stim_done   = 1'b0;
  int   send_gap    = 0;
  int   recv_gap    = 0;
  out_t want;

  regret_matching_normalizer u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  task automatic absorb_action(input in_t item);
    logic [63:0] scaled;
    out_t        res;
    if (weight_count < MAX_ACTIONS) begin
      clamped_weights[weight_count] = item.value[31] ? '0 : item.value[VAL_W-1:0];
      weight_sum += clamped_weights[weight_count];
      weight_count++;
    end
    if (item.last) begin
      for (int k = 0; k < weight_count; k++) begin
        if (weight_sum != 0) begin
          scaled = (64'(clamped_weights[k]) << FRAC_W) / 64'(weight_sum);
        end else begin
          scaled = 64'(ONE_Q16) / 64'(weight_count);
        end
        res.action_index = 6'(k);
        res.probability  = scaled[16:0];
        res.final_res    = (k + 1 == weight_count);
        expected_probs.push_back(res);
      end
      weight_sum   = '0;
      weight_count = 0;
    end
  endtask

  task automatic push_action(input logic [31:0] value, input logic last);
    in_t item;
    item.value = value;
    item.last  = last;
    pending_actions.push_back(item);
  endtask

  function automatic logic [31:0] random_weight(input set_flavor_t flavor);
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom_range(0, 1000);
      2: v = '0;
      3: v = {1'b0, 31'($urandom)};
      4: v = {1'b1, 31'($urandom)};
      default: v = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
    endcase
    if (flavor == NONNEG) begin
      v[31] = 1'b0;
    end else if (flavor == NONPOS && v != 0 && !v[31]) begin
      v = ~v;
    end
    return v;
  endfunction

  task automatic queue_set(input int len, input set_flavor_t flavor);
    for (int i = 0; i < len; i++) begin
      push_action(random_weight(flavor), i == len - 1);
    end
  endtask

  task automatic wait_drained();
    while (pending_actions.size() != 0 || in_valid || expected_probs.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Driver: inputs change on the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (in_valid && !in_taken) begin
      end else if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (pending_actions.size() > 0) begin
        in_data  <= pending_actions.pop_front();
        in_valid <= 1'b1;
        if (!(stim_done && pending_actions.size() < CALM_ITEMS) &&
            $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(1, 13);
        end
      end else begin
        in_valid <= 1'b0;
      end
      in_taken = 1'b0;

      if (recv_gap > 0) begin
        out_ready <= 1'b0;
        recv_gap--;
      end else begin
        out_ready <= 1'b1;
        if (!(stim_done && pending_actions.size() < CALM_ITEMS) &&
            $urandom_range(0, 7) == 0) begin
          recv_gap = $urandom_range(1, 13);
        end
      end
    end
  end

  // Monitor: every transaction is sampled on the rising edge.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL regret_matching_normalizer");
      $finish;
    end else if (rst_n) begin
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        absorb_action(in_data);
      end
      if (out_valid && out_ready) begin
        if (expected_probs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected transaction: index %0d probability %0d final %0b",
                     out_data.action_index, out_data.probability, out_data.final_res);
          end
        end else begin
          want = expected_probs.pop_front();
          if (out_data.action_index !== want.action_index ||
              out_data.probability  !== want.probability  ||
              out_data.final_res    !== want.final_res) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected index %0d probability %0d final %0b,",
                       want.action_index, want.probability, want.final_res,
                       " got index %0d probability %0d final %0b",
                       out_data.action_index, out_data.probability, out_data.final_res);
            end
          end
        end
      end
    end
  end

  initial begin
    int          queued;
    int          len;
    set_flavor_t flavor;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    push_action(32'h7fff_ffff, 1'b1);
    push_action(32'h0000_0000, 1'b1);
    push_action(32'h8000_0000, 1'b1);
    push_action(32'hffff_ffff, 1'b0);
    push_action(32'h0000_0000, 1'b0);
    push_action(32'hffff_fffb, 1'b1);
    push_action(32'h7fff_ffff, 1'b0);
    push_action(32'h7fff_ffff, 1'b0);
    push_action(32'h0000_0001, 1'b0);
    push_action(32'h8000_0000, 1'b1);
    push_action(32'h0000_0001, 1'b0);
    push_action(32'h0000_0002, 1'b0);
    push_action(32'h0000_0003, 1'b0);
    push_action(32'h5555_5555, 1'b0);
    push_action(32'haaaa_aaaa, 1'b1);
    push_action(32'h4000_0000, 1'b0);
    push_action(32'h3fff_ffff, 1'b0);
    push_action(32'h0000_0001, 1'b0);
    push_action(32'h0000_0000, 1'b1);
    push_action(32'h0000_0000, 1'b0);
    push_action(32'h0000_0000, 1'b0);
    push_action(32'h0000_0007, 1'b1);

    // The sender holds off here until the whole directed stream has come back.
    wait_drained();

    queue_set(MAX_ACTIONS + 3, MIXED);
    queued = MAX_ACTIONS + 3;
    while (queued < RANDOM_ITEMS) begin
      len = ($urandom_range(0, 29) == 0) ? MAX_ACTIONS : $urandom_range(1, 8);
      case ($urandom_range(0, 4))
        0: flavor = NONPOS;
        1: flavor = NONNEG;
        default: flavor = MIXED;
      endcase
      queue_set(len, flavor);
      queued += len;
    end
    stim_done = 1'b1;

    wait_drained();
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS regret_matching_normalizer");
    end else begin
      $display("FAIL regret_matching_normalizer");
    end
    $finish;
  end

endmodule
